[hdl/iikl_pkg.sv]
`timescale 1ns / 1ps
package iikl_pkg;

    // Name comparison limits
    localparam int NAME_CHARS_DEF = 8;
    localparam int IDX_W          = 4;

    // Configuration register indexes
    localparam logic [2:0] CFG_SECTION_TEXT   = 3'd0;
    localparam logic [2:0] CFG_SECTION_LENGTH = 3'd1;
    localparam logic [2:0] CFG_KEY_TEXT       = 3'd2;
    localparam logic [2:0] CFG_KEY_LENGTH     = 3'd3;
    localparam logic [2:0] CFG_FALLBACK       = 3'd4;

    // Characters of interest
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [4:0] NO_DIGIT  = 5'd16;

    // Line phases
    localparam logic [1:0] LP_START = 2'd0;
    localparam logic [1:0] LP_SKIP  = 2'd1;
    localparam logic [1:0] LP_LINE  = 2'd2;
    localparam logic [1:0] LP_DONE  = 2'd3;

    // Value parser phases
    localparam logic [2:0] VP_LEAD     = 3'd0;
    localparam logic [2:0] VP_SIGNED   = 3'd1;
    localparam logic [2:0] VP_ZERO     = 3'd2;
    localparam logic [2:0] VP_HEXFIRST = 3'd3;
    localparam logic [2:0] VP_DIGITS   = 3'd4;
    localparam logic [2:0] VP_TAIL     = 3'd5;
    localparam logic [2:0] VP_OK       = 3'd6;
    localparam logic [2:0] VP_FAIL     = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             mm;
    } cmp_t;

    // Classified input item
    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] low;
        logic       blank;
        logic       eol;
        logic [4:0] dec;
        logic [4:0] hexd;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [63:0] sec_text;
        logic [3:0]  sec_len;
        logic [63:0] key_text;
        logic [3:0]  key_len;
        logic [31:0] fallback;
    } cfg_t;

    typedef struct packed {
        logic [31:0] value;
        logic        found;
        logic        parsed;
    } res_t;

    typedef struct packed {
        logic [1:0]  lp;
        logic        act;
        logic        sb;
        logic        inner;
        logic        pb;
        logic        seq;
        logic        kok;
        cmp_t        hr;
        cmp_t        hl;
        cmp_t        hp;
        cmp_t        kr;
        cmp_t        kl;
        logic [2:0]  vp;
        logic        neg;
        logic        hex;
        logic [31:0] acc;
    } st_t;

    typedef struct packed {
        st_t  s;
        logic emit;
        res_t r;
    } le_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
    endfunction

    function automatic cmp_t cmp_feed(input cmp_t s, input logic [7:0] lc,
                                      input logic [63:0] text, input logic [3:0] len,
                                      input logic [3:0] nmax);
        cmp_t o;
        o = s;
        if (s.idx < len && s.idx < nmax) begin
            if (to_lower(text[{s.idx[2:0], 3'b000} +: 8]) != lc)
                o.mm = 1'b1;
            o.idx = s.idx + 4'd1;
        end else begin
            o.mm = 1'b1;
        end
        return o;
    endfunction

    function automatic logic cmp_hit(input cmp_t s, input logic [3:0] len,
                                     input logic [3:0] nmax);
        return len >= 4'd1 && len <= nmax && !s.mm && s.idx == len;
    endfunction

    function automatic st_t line_clear(input st_t s);
        st_t o;
        o     = '0;
        o.lp  = s.lp;
        o.act = s.act;
        o.vp  = VP_LEAD;
        return o;
    endfunction

    function automatic st_t digits_step(input st_t s, input item_t q);
        st_t         o;
        logic [4:0]  d;
        logic [35:0] prod;
        logic [35:0] sum;
        o    = s;
        d    = s.hex ? q.hexd : q.dec;
        prod = s.hex ? {s.acc, 4'b0000}
                     : ({1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0});
        sum  = prod + {32'd0, d[3:0]};
        if (!d[4]) begin
            if (sum[35:32] != 4'd0)
                o.vp = VP_FAIL;
            else
                o.acc = sum[31:0];
        end else if (q.blank) begin
            o.vp = VP_TAIL;
        end else if (q.ch == CH_SEMI) begin
            o.vp = VP_OK;
        end else begin
            o.vp = VP_FAIL;
        end
        return o;
    endfunction

    function automatic st_t value_feed(input st_t s, input item_t q);
        st_t o;
        o = s;
        case (s.vp)
            VP_LEAD, VP_SIGNED:
            begin
                if (s.vp == VP_LEAD && q.blank) begin
                    o = s;
                end else if (s.vp == VP_LEAD && (q.ch == CH_PLUS || q.ch == CH_MINUS)) begin
                    o.neg = (q.ch == CH_MINUS);
                    o.vp  = VP_SIGNED;
                end else if (q.ch == CH_ZERO) begin
                    o.acc = 32'd0;
                    o.vp  = VP_ZERO;
                end else if (q.dec != NO_DIGIT) begin
                    o.acc = {28'd0, q.dec[3:0]};
                    o.hex = 1'b0;
                    o.vp  = VP_DIGITS;
                end else begin
                    o.vp = VP_FAIL;
                end
            end
            VP_ZERO:
            begin
                if (q.low == CH_X) begin
                    o.hex = 1'b1;
                    o.acc = 32'd0;
                    o.vp  = VP_HEXFIRST;
                end else begin
                    o.hex = 1'b0;
                    o.vp  = VP_DIGITS;
                    o     = digits_step(o, q);
                end
            end
            VP_HEXFIRST:
            begin
                if (q.hexd != NO_DIGIT) begin
                    o.acc = {28'd0, q.hexd[3:0]};
                    o.vp  = VP_DIGITS;
                end else begin
                    o.vp = VP_FAIL;
                end
            end
            VP_DIGITS:
            begin
                o = digits_step(s, q);
            end
            VP_TAIL:
            begin
                if (q.ch == CH_SEMI)
                    o.vp = VP_OK;
                else if (!q.blank)
                    o.vp = VP_FAIL;
            end
            default:
            begin
                o = s;
            end
        endcase
        return o;
    endfunction

    function automatic st_t line_feed(input st_t s, input item_t q, input cfg_t c,
                                      input logic [3:0] nmax);
        st_t o;
        o = s;
        if (!q.blank)
            o.pb = (q.ch == CH_RBRK);
        if (o.sb) begin
            if (!o.inner && !q.blank)
                o.inner = 1'b1;
            if (o.inner) begin
                o.hr = cmp_feed(o.hr, q.low, c.sec_text, c.sec_len, nmax);
                if (!q.blank) begin
                    o.hp = o.hl;
                    o.hl = o.hr;
                end
            end
        end
        if (!o.seq) begin
            if (q.ch == CH_EQ) begin
                o.seq = 1'b1;
                o.kok = cmp_hit(o.kl, c.key_len, nmax);
            end else begin
                o.kr = cmp_feed(o.kr, q.low, c.key_text, c.key_len, nmax);
                if (!q.blank)
                    o.kl = o.kr;
            end
        end else begin
            o = value_feed(o, q);
        end
        return o;
    endfunction

    function automatic le_t line_end(input st_t s, input cfg_t c, input logic [3:0] nmax);
        le_t  o;
        logic ok;
        o      = '0;
        o.s    = s;
        ok     = s.vp == VP_ZERO || s.vp == VP_DIGITS || s.vp == VP_TAIL || s.vp == VP_OK;
        o.s.lp = LP_START;
        if (s.sb && s.pb) begin
            o.s.act = cmp_hit(s.hp, c.sec_len, nmax);
        end else if (s.act && s.seq && s.kok) begin
            o.emit     = 1'b1;
            o.r.value  = ok ? (s.neg ? 32'd0 - s.acc : s.acc) : c.fallback;
            o.r.found  = 1'b1;
            o.r.parsed = ok;
            o.s.lp     = LP_DONE;
        end
        return o;
    endfunction

endpackage

[hdl/ini_integer_key_lookup.sv]
`timescale 1ns / 1ps
// INI integer key lookup.
// Input channel (in_valid/in_ready) takes one text byte per item with
// last_byte marking the end of a text. Output channel (out_valid/out_ready)
// delivers exactly one item per text: result_value, key_found, value_parsed.
// Configuration is written through cfg_write/cfg_index/cfg_data: 0 section
// text, 1 section length, 2 key text, 3 key length, 4 fallback. The user
// must write it only while idle; the block itself does not enforce this.
// A classifier and a two-entry queue feed a parser that handles one byte per
// cycle unless a result waits unaccepted, so the block sustains one byte per
// cycle while the receiver keeps up. The byte that settles the search is
// queued; when the parser pops it, it loads the output register and
// out_valid rises. The per-cycle limit is the parser step: section and key
// name compares, one x10/x16 multiply-add with overflow check. When the
// receiver stalls, the result waits in the output register and the parser
// takes no byte from the queue until it is accepted; the queue fills, after
// which in_ready drops. Reset empties the queue, drops any pending result,
// clears the parser, sets both name lengths to 1 and other config fields to 0.
module ini_integer_key_lookup #(
    parameter int NAME_CHARS = iikl_pkg::NAME_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_value,
    output logic        key_found,
    output logic        value_parsed,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import iikl_pkg::*;

    cfg_t  cfg_reg;
    logic  q_valid;
    logic  pop;
    item_t q_item;
    res_t  res;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{sec_text: 64'd0, sec_len: 4'd1, key_text: 64'd0,
                         key_len: 4'd1, fallback: 32'd0};
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SECTION_TEXT:   cfg_reg.sec_text <= cfg_data;
                CFG_SECTION_LENGTH: cfg_reg.sec_len  <= cfg_data[3:0];
                CFG_KEY_TEXT:       cfg_reg.key_text <= cfg_data;
                CFG_KEY_LENGTH:     cfg_reg.key_len  <= cfg_data[3:0];
                CFG_FALLBACK:       cfg_reg.fallback <= cfg_data[31:0];
                default:            cfg_reg          <= cfg_reg;
            endcase
        end
    end

    iikl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    iikl_back #(
        .NAME_CHARS (NAME_CHARS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign result_value = res.value;
    assign key_found    = res.found;
    assign value_parsed = res.parsed;

endmodule

[hdl/iikl_front.sv]
`timescale 1ns / 1ps
module iikl_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    input  logic          pop,
    output logic          q_valid,
    output iikl_pkg::item_t q_item
);
    import iikl_pkg::*;

    item_t      slot_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      cls;
    logic       push;

    // Classify the incoming byte
    always_comb
    begin
        cls.ch    = data_byte;
        cls.low   = to_lower(data_byte);
        cls.blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB);
        cls.eol   = (data_byte == CH_LF) || (data_byte == CH_CR);
        cls.last  = last_byte;
        if (data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
            cls.dec  = {1'b0, data_byte[3:0]};
            cls.hexd = {1'b0, data_byte[3:0]};
        end else begin
            cls.dec  = NO_DIGIT;
            if (cls.low >= CH_LA && cls.low <= CH_LF_HEX)
                cls.hexd = {1'b0, cls.low[3:0] + 4'd9};
            else
                cls.hexd = NO_DIGIT;
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_reg];

    // Advance queue pointers
    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold queued items
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= cls;
    end

endmodule

[hdl/iikl_back.sv]
`timescale 1ns / 1ps
module iikl_back #(
    parameter int NAME_CHARS = iikl_pkg::NAME_CHARS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  iikl_pkg::item_t q_item,
    output logic           pop,
    input  iikl_pkg::cfg_t cfg,
    output logic           out_valid,
    input  logic           out_ready,
    output iikl_pkg::res_t res
);
    import iikl_pkg::*;

    localparam logic [3:0] NMAX = 4'(NAME_CHARS);

    st_t  st_reg, st_next;
    logic ov_reg, ov_next;
    res_t res_reg, res_next;
    logic emit;
    le_t  le;

    assign pop       = q_valid && (!ov_reg || out_ready);
    assign out_valid = ov_reg;
    assign res       = res_reg;

    // Run one byte through the line and value parsers
    always_comb
    begin
        st_next  = st_reg;
        emit     = 1'b0;
        res_next = res_reg;
        le       = '0;
        if (pop) begin
            if (st_next.lp != LP_DONE) begin
                if (q_item.eol) begin
                    if (st_next.lp == LP_LINE) begin
                        le       = line_end(st_next, cfg, NMAX);
                        st_next  = le.s;
                        emit     = le.emit;
                        res_next = le.emit ? le.r : res_next;
                    end else begin
                        st_next.lp = LP_START;
                    end
                end else if (st_next.lp == LP_START) begin
                    if (!q_item.blank) begin
                        if (q_item.ch == CH_SEMI || q_item.ch == CH_HASH) begin
                            st_next.lp = LP_SKIP;
                        end else if (q_item.ch == CH_LBRK || st_next.act) begin
                            st_next    = line_clear(st_next);
                            st_next.sb = (q_item.ch == CH_LBRK);
                            st_next.lp = LP_LINE;
                            if (st_next.sb) begin
                                st_next.pb = 1'b0;
                                st_next.kr = cmp_feed(st_next.kr, q_item.low, cfg.key_text,
                                                      cfg.key_len, NMAX);
                                st_next.kl = st_next.kr;
                            end else begin
                                st_next = line_feed(st_next, q_item, cfg, NMAX);
                            end
                        end else begin
                            st_next.lp = LP_SKIP;
                        end
                    end
                end else if (st_next.lp == LP_LINE) begin
                    st_next = line_feed(st_next, q_item, cfg, NMAX);
                end
            end
            // Close the text on its last byte
            if (q_item.last) begin
                if (st_next.lp == LP_LINE) begin
                    le       = line_end(st_next, cfg, NMAX);
                    st_next  = le.s;
                    emit     = le.emit;
                    res_next = le.emit ? le.r : res_next;
                end
                if (!emit && st_next.lp != LP_DONE) begin
                    emit            = 1'b1;
                    res_next.value  = cfg.fallback;
                    res_next.found  = 1'b0;
                    res_next.parsed = 1'b0;
                end
                st_next     = line_clear(st_next);
                st_next.lp  = LP_START;
                st_next.act = 1'b0;
            end
        end
        ov_next = emit ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // Never pop an empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
        else $error("pop from empty queue");

    // A stalled result blocks the parser
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |-> !pop)
        else $error("pop while result stalled");

    // A missing key never reports a parsed value
    a_notfound: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !res_reg.found) |-> !res_reg.parsed)
        else $error("parsed without key");

    // Once done, the next result waits for the last byte
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.lp == LP_DONE && pop && !q_item.last) |=> !($rose(ov_reg)))
        else $error("result after search settled");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
    import iikl_pkg::*;

    typedef struct {
        int idx;
        bit mm;
    } name_cmp_t;

    typedef enum int {
        LN_SEC_HIT, LN_SEC_OTHER, LN_KEY_HIT, LN_KEY_OTHER, LN_COMMENT, LN_NOISE
    } line_kind_e;

    // Predict lookup results from the byte stream and check the block against them
    class lookup_scoreboard;
        bit [63:0] sec_text, key_text;
        bit [3:0]  sec_len, key_len;
        bit [31:0] fallback;
        bit [1:0]  phase;
        bit        active, starts_brk, inner, pend_brk, saw_eq, key_ok;
        name_cmp_t hr, hl, hp, kr, kl;
        bit [2:0]  vphase;
        bit        neg, hex;
        bit [31:0] acc;
        res_t      lookups[$];
        int        mismatches;

        function bit [7:0] lower(bit [7:0] c);
            return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
        endfunction

        function bit is_blank(bit [7:0] c);
            return c == CH_SPACE || c == CH_TAB;
        endfunction

        function name_cmp_t fed(name_cmp_t s, bit [7:0] c, bit [63:0] txt, bit [3:0] len);
            name_cmp_t o;
            o = s;
            if (s.idx < len && s.idx < NAME_CHARS_DEF) begin
                if (lower(txt[8*s.idx +: 8]) != lower(c))
                    o.mm = 1;
                o.idx = s.idx + 1;
            end else begin
                o.mm = 1;
            end
            return o;
        endfunction

        function bit hit(name_cmp_t s, bit [3:0] len);
            return len >= 1 && len <= NAME_CHARS_DEF && !s.mm && s.idx == len;
        endfunction

        function int digit(bit [7:0] c, bit hx);
            bit [7:0] l;
            l = lower(c);
            if (c >= CH_ZERO && c <= CH_NINE)
                return c - CH_ZERO;
            if (hx && l >= CH_LA && l <= CH_LF_HEX)
                return l - CH_LA + 10;
            return 16;
        endfunction

        function void digits(bit [7:0] c);
            int        d;
            bit [31:0] base;
            d    = digit(c, hex);
            base = hex ? 32'd16 : 32'd10;
            if (d < 16) begin
                if (acc > (32'hFFFF_FFFF - d) / base)
                    vphase = VP_FAIL;
                else
                    acc = acc * base + d;
            end else if (is_blank(c)) begin
                vphase = VP_TAIL;
            end else if (c == CH_SEMI) begin
                vphase = VP_OK;
            end else begin
                vphase = VP_FAIL;
            end
        endfunction

        function void first_digit(bit [7:0] c);
            if (c == CH_ZERO) begin
                acc = 0;
                vphase = VP_ZERO;
            end else if (c > CH_ZERO && c <= CH_NINE) begin
                acc = {24'd0, c - CH_ZERO};
                hex = 0;
                vphase = VP_DIGITS;
            end else begin
                vphase = VP_FAIL;
            end
        endfunction

        function void value_feed(bit [7:0] c);
            int d;
            case (vphase)
                VP_LEAD:
                begin
                    if (is_blank(c))
                        return;
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        neg = (c == CH_MINUS);
                        vphase = VP_SIGNED;
                    end else begin
                        first_digit(c);
                    end
                end
                VP_SIGNED:
                    first_digit(c);
                VP_ZERO:
                begin
                    if (lower(c) == CH_X) begin
                        hex = 1;
                        acc = 0;
                        vphase = VP_HEXFIRST;
                    end else begin
                        hex = 0;
                        vphase = VP_DIGITS;
                        digits(c);
                    end
                end
                VP_HEXFIRST:
                begin
                    d = digit(c, 1);
                    if (d < 16) begin
                        acc = d;
                        vphase = VP_DIGITS;
                    end else begin
                        vphase = VP_FAIL;
                    end
                end
                VP_DIGITS:
                    digits(c);
                VP_TAIL:
                begin
                    if (c == CH_SEMI)
                        vphase = VP_OK;
                    else if (!is_blank(c))
                        vphase = VP_FAIL;
                end
                default: ;
            endcase
        endfunction

        function void line_clear();
            name_cmp_t e;
            e = '{0, 0};
            starts_brk = 0; inner = 0; pend_brk = 0; saw_eq = 0; key_ok = 0;
            hr = e; hl = e; hp = e; kr = e; kl = e;
            vphase = VP_LEAD; neg = 0; hex = 0; acc = 0;
        endfunction

        function void text_clear();
            phase = LP_START;
            active = 0;
            line_clear();
        endfunction

        function void reset();
            sec_text = 0; key_text = 0; sec_len = 1; key_len = 1; fallback = 0;
            text_clear();
            lookups.delete();
            mismatches = 0;
        endfunction

        function void configure(bit [2:0] idx, bit [63:0] val);
            case (idx)
                CFG_SECTION_TEXT:   sec_text = val;
                CFG_SECTION_LENGTH: sec_len = val[3:0];
                CFG_KEY_TEXT:       key_text = val;
                CFG_KEY_LENGTH:     key_len = val[3:0];
                CFG_FALLBACK:       fallback = val[31:0];
                default: ;
            endcase
        endfunction

        function void line_feed(bit [7:0] c);
            bit b;
            b = is_blank(c);
            if (!b)
                pend_brk = (c == CH_RBRK);
            if (starts_brk) begin
                if (!inner && !b)
                    inner = 1;
                if (inner) begin
                    hr = fed(hr, c, sec_text, sec_len);
                    if (!b) begin
                        hp = hl;
                        hl = hr;
                    end
                end
            end
            if (!saw_eq) begin
                if (c == CH_EQ) begin
                    saw_eq = 1;
                    key_ok = hit(kl, key_len);
                end else begin
                    kr = fed(kr, c, key_text, key_len);
                    if (!b)
                        kl = kr;
                end
            end else begin
                value_feed(c);
            end
        endfunction

        // Close a line; return 1 when it settles the search
        function bit line_end();
            bit   ok;
            res_t r;
            if (starts_brk && pend_brk) begin
                active = hit(hp, sec_len);
            end else if (active && saw_eq && key_ok) begin
                ok = vphase == VP_ZERO || vphase == VP_DIGITS ||
                     vphase == VP_TAIL || vphase == VP_OK;
                r.value  = ok ? (neg ? 32'd0 - acc : acc) : fallback;
                r.found  = 1;
                r.parsed = ok;
                lookups.push_back(r);
                phase = LP_DONE;
                return 1;
            end
            phase = LP_START;
            return 0;
        endfunction

        // Note one accepted byte
        function void note_byte(bit [7:0] c, bit last);
            bit   got;
            res_t r;
            got = 0;
            if (phase != LP_DONE) begin
                if (c == CH_LF || c == CH_CR) begin
                    if (phase == LP_LINE)
                        got = line_end();
                    else
                        phase = LP_START;
                end else if (phase == LP_START) begin
                    if (!is_blank(c)) begin
                        if (c == CH_SEMI || c == CH_HASH) begin
                            phase = LP_SKIP;
                        end else if (c == CH_LBRK || active) begin
                            line_clear();
                            starts_brk = (c == CH_LBRK);
                            phase = LP_LINE;
                            if (starts_brk) begin
                                pend_brk = 0;
                                kr = fed(kr, c, key_text, key_len);
                                kl = kr;
                            end else begin
                                line_feed(c);
                            end
                        end else begin
                            phase = LP_SKIP;
                        end
                    end
                end else if (phase == LP_LINE) begin
                    line_feed(c);
                end
            end
            if (last) begin
                if (phase == LP_LINE)
                    got = line_end();
                if (!got && phase != LP_DONE) begin
                    r.value = fallback; r.found = 0; r.parsed = 0;
                    lookups.push_back(r);
                end
                text_clear();
            end
        endfunction

        // Compare one delivered result with the oldest prediction
        function void check_result(bit [31:0] v, bit f, bit p);
            res_t e;
            if (lookups.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h found=%b parsed=%b", v, f, p);
                return;
            end
            e = lookups.pop_front();
            if (e.value !== v || e.found !== f || e.parsed !== p) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value=%h found=%b parsed=%b, got %h %b %b",
                             e.value, e.found, e.parsed, v, f, p);
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        in_valid, in_ready, last_byte;
    logic [7:0]  data_byte;
    logic        out_valid, out_ready, key_found, value_parsed;
    logic [31:0] result_value;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    lookup_scoreboard sb;
    bit        calm;
    int        idle_cycles;
    int        sent;
    bit [7:0]  text_bytes[$];
    bit [63:0] sec_name, key_name;
    bit [3:0]  sec_n, key_n;

    ini_integer_key_lookup dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_value(result_value), .key_found(key_found), .value_parsed(value_parsed),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 2000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: stall at random before each result item
    initial
    begin : receiver
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(result_value, key_found, value_parsed);
        end
    end

    // Offer one byte and hold it until accepted
    task send_byte(input bit [7:0] b, input bit last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b, last);
        sent++;
    endtask

    // Drive the built text, last flag on its final byte
    task send_text();
        foreach (text_bytes[i])
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        text_bytes.delete();
    endtask

    // Drop valid and drain all pending results
    task drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.lookups.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    task write_regs(input bit [63:0] st, input bit [3:0] sl, input bit [63:0] kt,
                    input bit [3:0] kl, input bit [31:0] fb);
        bit [63:0] vals[5];
        vals = '{st, {60'd0, sl}, kt, {60'd0, kl}, {32'd0, fb}};
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= vals[i];
            sb.configure(i[2:0], vals[i]);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        sec_name = st; sec_n = sl; key_name = kt; key_n = kl;
    endtask

    task push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_bytes.push_back(s[i]);
    endtask

    task push_blanks(input int maxn);
        repeat ($urandom_range(0, maxn))
            text_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    // Push the first n chars of a name, at most NAME_CHARS_DEF, with random letter case
    task push_name(input bit [63:0] nm, input bit [3:0] n);
        bit [7:0] c;
        for (int i = 0; i < n && i < NAME_CHARS_DEF; i++)
        begin
            c = nm[8*i +: 8];
            if (((c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= 8'h7A)) && $urandom_range(0, 1))
                c = c ^ 8'h20;
            text_bytes.push_back(c);
        end
    endtask

    task push_value();
        bit [31:0] v;
        string     s;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: s = $sformatf("%0d", v);
            1: s = $sformatf("0%s%0h", $urandom_range(0, 1) ? "x" : "X", v);
            2: s = $sformatf("%s%0d", $urandom_range(0, 1) ? "-" : "+", v >> $urandom_range(0, 31));
            3: s = $urandom_range(0, 1) ? "4294967295" : "0xFFFFFFFF";
            4: s = $urandom_range(0, 1) ? "4294967296" : "0x100000000";
            5: s = $urandom_range(0, 1) ? "0" : "-0x8000000A";
            6: s = $urandom_range(0, 2) == 0 ? "0x" : ($urandom_range(0, 1) ? "-" : "");
            7: s = $sformatf("%0d%s", v[7:0], $urandom_range(0, 1) ? "g" : "x1");
            8: s = $sformatf("00%0d", v[9:0]);
            default: s = $sformatf("%0d", v[15:0]);
        endcase
        push_str(s);
        push_blanks(2);
        if ($urandom_range(0, 2) == 0)
            push_str($urandom_range(0, 3) ? "; note" : "junk");
    endtask

    // Build one random line of the given kind, with a line end when ended is set
    task push_line(input line_kind_e k, input bit ended);
        push_blanks(1);
        case (k)
            LN_SEC_HIT, LN_SEC_OTHER:
            begin
                text_bytes.push_back(CH_LBRK);
                push_blanks(1);
                if (k == LN_SEC_HIT)
                    push_name(sec_name, $urandom_range(0, 7) ? sec_n : sec_n - 4'd1);
                else
                    push_str($urandom_range(0, 1) ? "other" : "x");
                push_blanks(1);
                if ($urandom_range(0, 7))
                    text_bytes.push_back(CH_RBRK);
                push_blanks(1);
            end
            LN_KEY_HIT, LN_KEY_OTHER:
            begin
                if (k == LN_KEY_HIT)
                    push_name(key_name, key_n);
                else
                    push_str("zz");
                if ($urandom_range(0, 7) == 0)
                    text_bytes.push_back(8'h71);
                push_blanks(2);
                if ($urandom_range(0, 9))
                    text_bytes.push_back(CH_EQ);
                push_blanks(2);
                push_value();
            end
            LN_COMMENT:
                push_str($urandom_range(0, 1) ? "; c=1" : "# [s]");
            default:
                repeat ($urandom_range(1, 6))
                    text_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
        if (ended)
        begin
            case ($urandom_range(0, 2))
                0: text_bytes.push_back(CH_LF);
                1: text_bytes.push_back(CH_CR);
                default:
                begin
                    text_bytes.push_back(CH_CR);
                    text_bytes.push_back(CH_LF);
                end
            endcase
        end
    endtask

    // Random name: mostly letters, sometimes any byte value
    function bit [63:0] rand_name();
        bit [63:0] nm;
        for (int i = 0; i < 8; i++)
            nm[8*i +: 8] = $urandom_range(0, 3) ? 8'(8'h61 + $urandom_range(0, 25))
                                                : 8'($urandom_range(0, 255));
        return nm;
    endfunction

    initial
    begin : stimulus
        int        nlines;
        int        phase_no;
        bit [3:0]  sl, kl;
        line_kind_e k;
        sb = new();
        sb.reset();
        calm        = 0;
        idle_cycles = 0;
        sent        = 0;
        in_valid    = 1'b0;
        data_byte   = 8'h00;
        last_byte   = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = CFG_SECTION_TEXT;
        cfg_data    = 64'd0;
        sec_name    = 0; key_name = 0; sec_n = 1; key_n = 1;
        rst_n       = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: section "main", key "port"
        write_regs(64'h6E69_616D, 4'd4, 64'h7472_6F70, 4'd4, 32'hDEAD_BEEF);
        push_str("[MAIN]\nport=0x1F\n");
        send_text();
        push_str(" [ main ] \nPort = -5 ;c");
        send_text();
        push_str("#\n[main]\rport=4294967296\n");
        send_text();
        push_str("x=1");
        text_bytes.push_back(8'hFF);
        send_text();
        drain();

        // Random phases; some with extreme or invalid lengths
        phase_no = 0;
        while (sent < 800)
        begin
            case (phase_no % 6)
                0: begin sl = 1; kl = 8; end
                1: begin sl = 8; kl = 1; end
                2: begin sl = 0; kl = 15; end
                default: begin sl = $urandom_range(1, 8); kl = $urandom_range(1, 8); end
            endcase
            write_regs(rand_name(), sl, rand_name(),
                       kl, phase_no == 1 ? 32'hFFFF_FFFF : $urandom);
            calm = (phase_no % 4 == 3);
            repeat ($urandom_range(3, 8))
            begin
                nlines = $urandom_range(1, 5);
                for (int i = 0; i < nlines; i++)
                begin
                    if (i == 0 && $urandom_range(0, 3))
                        k = LN_SEC_HIT;
                    else if ($urandom_range(0, 1))
                        k = LN_KEY_HIT;
                    else
                        k = line_kind_e'($urandom_range(0, 5));
                    push_line(k, i < nlines - 1 || $urandom_range(0, 1));
                end
                send_text();
            end
            calm = 0;
            drain();
            phase_no++;
        end

        // Let any trailing result arrive, then report
        drain();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.lookups.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[ini_integer_key_lookup.f]
hdl/iikl_pkg.sv
hdl/iikl_front.sv
hdl/iikl_back.sv
hdl/ini_integer_key_lookup.sv
tb/sv/tb.sv
